/* src/q15_atan2_polynomial_top_macros.svh */
// Assertion macros shared by the checkers of the arctangent block.
// Each macro expects a signal named clk in the scope of use, and all but QAT2_ASSERT_NXT_RST also rst_n.
`ifndef Q15_ATAN2_POLYNOMIAL_TOP_MACROS_SVH
`define Q15_ATAN2_POLYNOMIAL_TOP_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define QAT2_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off during reset.
`define QAT2_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define QAT2_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/qat2_pkg.sv */
`timescale 1ns / 1ps

package qat2_pkg;

  localparam int unsigned DIV_W = 16;
  localparam int unsigned REM_W = DIV_W + 1;

  localparam logic [11:0] POLY_B = 12'd2847;
  localparam logic [13:0] POLY_A = 14'd11039;

  localparam logic [15:0] ANG_EQ_POS   = 16'd8192;
  localparam logic [15:0] ANG_EQ_NEG   = 16'd40960;
  localparam logic [15:0] ANG_ZERO     = 16'd0;
  localparam logic [15:0] ANG_HALF     = 16'd32768;
  localparam logic [15:0] ANG_QUARTER  = 16'd16384;
  localparam logic [15:0] ANG_3QUARTER = 16'd49152;

  localparam logic [15:0] Q15_MIN_MAG = 16'h8000;
  localparam logic [14:0] Q15_MAX     = 15'h7fff;

  // Which octant rule forms the final angle
  typedef enum logic [2:0] {
    SEL_EQ_POS,
    SEL_EQ_NEG,
    SEL_ZERO,
    SEL_XPOS,
    SEL_XNEG,
    SEL_YPOS,
    SEL_YNEG
  } sel_t;

  // Work item travelling down the divider chain
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [DIV_W-1:0] quo;
    logic             neg;
    sel_t             sel;
  } div_t;

endpackage

/* src/qat2_div_cell.sv */
`timescale 1ns / 1ps

module qat2_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  qat2_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qat2_pkg::div_t  out_data
);

  logic                        valid_r;
  qat2_pkg::div_t              data_r;
  qat2_pkg::div_t              data_nxt;
  logic                        ge;
  logic [qat2_pkg::REM_W-1:0]  diff;
  logic [qat2_pkg::REM_W-1:0]  rem_sel;

  assign ge      = (in_data.rem >= {1'b0, in_data.den});
  assign diff    = in_data.rem - {1'b0, in_data.den};
  assign rem_sel = ge ? diff : in_data.rem;

  // One restoring step: take the quotient bit, then shift the remainder up
  always_comb begin
    data_nxt     = in_data;
    data_nxt.rem = {rem_sel[qat2_pkg::DIV_W-1:0], 1'b0};
    data_nxt.quo = {in_data.quo[qat2_pkg::DIV_W-2:0], ge};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* src/qat2_poly.sv */
`timescale 1ns / 1ps

module qat2_poly (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  qat2_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_angle
);

  // Stage 1: signed ratio and its saturated magnitude
  logic               v1_r;
  logic signed [15:0] r1_r;
  logic [14:0]        abs1_r;
  qat2_pkg::sel_t     sel1_r;
  // Stage 2: correction product
  logic               v2_r;
  logic signed [15:0] r2_r;
  logic [26:0]        prod1_r;
  qat2_pkg::sel_t     sel2_r;
  // Stage 3: second product
  logic               v3_r;
  logic signed [30:0] prod2_r;
  qat2_pkg::sel_t     sel3_r;
  // Stage 4: output register
  logic               v4_r;
  logic [15:0]        angle_r;

  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [15:0] r_nxt;
  logic [14:0]        abs_nxt;
  logic [26:0]        prod1_nxt;
  logic [13:0]        p_val;
  logic signed [30:0] prod2_nxt;
  logic [15:0]        u_val;
  logic [15:0]        angle_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    r_nxt = in_data.neg ? -$signed(in_data.quo) : $signed(in_data.quo);
    if (!r_nxt[15]) begin
      abs_nxt = r_nxt[14:0];
    end else if (r_nxt == $signed(qat2_pkg::Q15_MIN_MAG)) begin
      abs_nxt = qat2_pkg::Q15_MAX;
    end else begin
      abs_nxt = 15'(-r_nxt);
    end
  end

  assign prod1_nxt = 27'(qat2_pkg::POLY_B) * 27'(abs1_r);
  assign p_val     = qat2_pkg::POLY_A - 14'(prod1_r[26:15]);
  assign prod2_nxt = 31'($signed({1'b0, p_val})) * 31'(r2_r);
  assign u_val     = prod2_r[30:15];

  always_comb begin
    unique case (sel3_r)
      qat2_pkg::SEL_EQ_POS: angle_nxt = qat2_pkg::ANG_EQ_POS;
      qat2_pkg::SEL_EQ_NEG: angle_nxt = qat2_pkg::ANG_EQ_NEG;
      qat2_pkg::SEL_ZERO:   angle_nxt = qat2_pkg::ANG_ZERO;
      qat2_pkg::SEL_XPOS:   angle_nxt = u_val;
      qat2_pkg::SEL_XNEG:   angle_nxt = qat2_pkg::ANG_HALF + u_val;
      qat2_pkg::SEL_YPOS:   angle_nxt = qat2_pkg::ANG_QUARTER - u_val;
      qat2_pkg::SEL_YNEG:   angle_nxt = qat2_pkg::ANG_3QUARTER - u_val;
      default:              angle_nxt = qat2_pkg::ANG_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r1_r   <= r_nxt;
      abs1_r <= abs_nxt;
      sel1_r <= in_data.sel;
    end
    if (rdy2 && v1_r) begin
      r2_r    <= r1_r;
      prod1_r <= prod1_nxt;
      sel2_r  <= sel1_r;
    end
    if (rdy3 && v2_r) begin
      prod2_r <= prod2_nxt;
      sel3_r  <= sel2_r;
    end
    if (rdy4 && v3_r) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_angle = angle_r;

endmodule

/* src/q15_atan2_polynomial_top.sv */
`timescale 1ns / 1ps

// Channel  Direction  tdata fields (lowest bit up)           Transfer
// in_      slave      y_value[15:0], x_value[31:16], signed  in_tvalid & in_tready
// out_     master     angle[15:0], unsigned                  out_tvalid & out_tready
//
// One item per clock while the output is not stalled; the path holds one operand stage, sixteen
// divider cells (one quotient bit each) and four polynomial stages.
// The sixteen-cell divider chain makes up most of the latency.
// rst_n clears every valid bit; payload registers are not reset.
// Each stage holds only while it is full and its successor cannot take data,
// so bubbles close up and input transfers continue while a result waits, until every stage is full.

module q15_atan2_polynomial_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // y_value[15:0], x_value[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // angle[15:0]
);

  localparam int unsigned NCELL = qat2_pkg::DIV_W;

  logic signed [15:0] y_in;
  logic signed [15:0] x_in;
  logic [15:0]        abs_y;
  logic [15:0]        abs_x;
  logic [15:0]        sat_y;
  logic [15:0]        sat_x;
  qat2_pkg::div_t     prep_nxt;

  logic               ve_r;
  qat2_pkg::div_t     de_r;
  logic               rdy_e;

  qat2_pkg::div_t     d   [0:NCELL];
  logic               v   [0:NCELL];
  logic               rdy [0:NCELL];

  assign y_in  = $signed(in_tdata[15:0]);
  assign x_in  = $signed(in_tdata[31:16]);
  assign abs_y = y_in[15] ? 16'(-y_in) : 16'(y_in);
  assign abs_x = x_in[15] ? 16'(-x_in) : 16'(x_in);
  assign sat_y = (abs_y == qat2_pkg::Q15_MIN_MAG) ? {1'b0, qat2_pkg::Q15_MAX} : abs_y;
  assign sat_x = (abs_x == qat2_pkg::Q15_MIN_MAG) ? {1'b0, qat2_pkg::Q15_MAX} : abs_x;

  // Pick the octant and order the operands so the ratio stays within one turn/8
  always_comb begin
    prep_nxt.quo = '0;
    prep_nxt.neg = y_in[15] ^ x_in[15];
    if (x_in == y_in) begin
      prep_nxt.rem = '0;
      prep_nxt.den = abs_y;
      if (y_in == 16'sd0) begin
        prep_nxt.sel = qat2_pkg::SEL_ZERO;
      end else if (y_in[15]) begin
        prep_nxt.sel = qat2_pkg::SEL_EQ_NEG;
      end else begin
        prep_nxt.sel = qat2_pkg::SEL_EQ_POS;
      end
    end else if (sat_x > sat_y) begin
      prep_nxt.rem = {1'b0, abs_y};
      prep_nxt.den = abs_x;
      prep_nxt.sel = x_in[15] ? qat2_pkg::SEL_XNEG : qat2_pkg::SEL_XPOS;
    end else begin
      prep_nxt.rem = {1'b0, abs_x};
      prep_nxt.den = abs_y;
      prep_nxt.sel = y_in[15] ? qat2_pkg::SEL_YNEG : qat2_pkg::SEL_YPOS;
    end
  end

  assign rdy_e     = !ve_r || rdy[0];
  assign in_tready = rdy_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (rdy_e) begin
      ve_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && in_tvalid) begin
      de_r <= prep_nxt;
    end
  end

  assign d[0] = de_r;
  assign v[0] = ve_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    qat2_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .in_data   (d[i]),
      .out_valid (v[i+1]),
      .out_ready (rdy[i+1]),
      .out_data  (d[i+1])
    );
  end

  qat2_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v[NCELL]),
    .in_ready  (rdy[NCELL]),
    .in_data   (d[NCELL]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_angle (out_tdata)
  );

endmodule

/* src/qat2_checker.sv */
`timescale 1ns / 1ps
`include "q15_atan2_polynomial_top_macros.svh"

module qat2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic in_xfer;

  assign in_xfer = in_tvalid && in_tready && (in_tdata == in_tdata);

  `QAT2_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `QAT2_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")
  `QAT2_ASSERT_NXT_RST(a_rst_empty, !rst_n, !out_tvalid, "result presented straight after reset")
  `QAT2_ASSERT_IMP(a_ready_free, !out_tvalid || out_tready, in_tready || in_xfer, "input blocked with free output")

endmodule

bind q15_atan2_polynomial_top qat2_checker u_qat2_checker (.*);

/* bench/tb_q15_atan2_polynomial_top.sv */
`timescale 1ns / 1ps

module tb_q15_atan2_polynomial_top;

  localparam int LATENCY = 21;

  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [15:0]        angle;
  } angle_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // y_value[15:0], x_value[31:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // angle[15:0]

  angle_exp_t angle_q[$];
  int         error_count = 0;
  bit         idle_en = 1'b1;
  bit         stall_en = 1'b1;
  int         hold_left = 0;
  int         stall_left = 0;

  q15_atan2_polynomial_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_mag(longint v);
    if (v < -32767) return 32767;
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint to_s16(longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return t;
  endfunction

  function automatic longint q15_mul(longint a, longint b);
    return to_s16((a * b) >>> 15);
  endfunction

  // Truncating divide, saturating on a zero or too small divisor
  function automatic longint q15_div(longint num, longint den);
    if (den == 0 || sat_mag(den) < sat_mag(num))
      return ((num < 0) != (den < 0)) ? -32768 : 32767;
    return to_s16((32768 * num) / den);
  endfunction

  function automatic longint octant_poly(longint r);
    longint corr;
    corr = q15_mul(2847, sat_mag(r));
    return q15_mul(to_s16(11039 - corr), r);
  endfunction

  function automatic logic [15:0] atan2_angle(logic signed [15:0] y16,
                                              logic signed [15:0] x16);
    longint y;
    longint x;
    longint u;
    longint ang;
    y = y16;
    x = x16;
    if (x == y) begin
      ang = (y > 0) ? 8192 : (y < 0) ? 40960 : 0;
    end else if (sat_mag(x) > sat_mag(y)) begin
      u = octant_poly(q15_div(y, x));
      ang = (x > 0) ? u : 32768 + u;
    end else begin
      u = octant_poly(q15_div(x, y));
      ang = (y > 0) ? 16384 - u : 49152 - u;
    end
    return ang[15:0];
  endfunction

  // ---------------------------------------------------------------- helpers

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  task automatic send_pair(logic signed [15:0] y, logic signed [15:0] x);
    int gap;
    angle_exp_t e;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {x, y};
    do @(posedge clk); while (!in_tready);
    e.y = y;
    e.x = x;
    e.angle = atan2_angle(y, x);
    angle_q.push_back(e);
  endtask

  // Result side: a long hold-off when asked, otherwise random stalls when enabled
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (stall_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Compare each result transfer with the oldest pending angle
  always @(posedge clk) begin
    angle_exp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (angle_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result angle=%0d", out_tdata));
      end else begin
        e = angle_q.pop_front();
        if (out_tdata !== e.angle)
          report_mismatch($sformatf("y=%0d x=%0d: angle %0d, predicted %0d",
                                    e.y, e.x, out_tdata, e.angle));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_equal_inputs();
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd1, 16'sd1);
    send_pair(-16'sd1, -16'sd1);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd12345, 16'sd12345);
  endtask

  // Saturated magnitudes, equal magnitudes of opposite sign, zero components
  task automatic test_extreme_magnitudes();
    send_pair(16'sd32767, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(-16'sd32767, 16'sd32767);
    send_pair(16'sd32767, -16'sd32767);
    send_pair(16'sd100, -16'sd100);
    send_pair(16'sd0, 16'sd32767);
    send_pair(16'sd0, -16'sd32768);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd0);
  endtask

  task automatic test_octants();
    send_pair(16'sd1000, 16'sd3000);
    send_pair(16'sd3000, 16'sd1000);
    send_pair(16'sd3000, -16'sd1000);
    send_pair(16'sd1000, -16'sd3000);
    send_pair(-16'sd1000, -16'sd3000);
    send_pair(-16'sd3000, -16'sd1000);
    send_pair(-16'sd3000, 16'sd1000);
    send_pair(-16'sd1000, 16'sd3000);
  endtask

  task automatic test_random_pairs(int count);
    logic signed [15:0] y;
    logic signed [15:0] x;
    for (int i = 0; i < count; i++) begin
      // rotate between stretches without idling, without output stalls, and with both
      if (i % 50 == 0) begin
        idle_en  = ((i / 50) % 3 != 0);
        stall_en = ((i / 50) % 3 != 1);
      end
      y = 16'($urandom_range(0, 65535));
      x = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
        4: x = y;
        5: x = -y;
        6: begin
          case ($urandom_range(0, 2))
            0: x = 16'sh8000;
            1: x = 16'sh7fff;
            default: x = 16'sd0;
          endcase
          if ($urandom_range(0, 1)) begin
            y = x;
            x = 16'($urandom_range(0, 65535));
          end
        end
        7: x = y + $signed(16'($urandom_range(0, 6))) - 16'sd3;
        8: begin
          y = $signed(16'($urandom_range(0, 16))) - 16'sd8;
          x = $signed(16'($urandom_range(0, 16))) - 16'sd8;
        end
        9: if ($urandom_range(0, 1)) x = 16'sd0; else y = 16'sd0;
        default: ;
      endcase
      send_pair(y, x);
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  // Hold the result side off long enough that the pipeline fills and
  // back-pressure reaches the input
  task automatic test_output_stall();
    idle_en   = 1'b0;
    stall_en  = 1'b0;
    hold_left = 4 * LATENCY + 20;
    for (int i = 0; i < 80; i++)
      send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_equal_inputs();
    test_extreme_magnitudes();
    test_octants();
    test_random_pairs(640);
    test_output_stall();
    in_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/qat2_pkg.sv
src/qat2_div_cell.sv
src/qat2_poly.sv
src/q15_atan2_polynomial_top.sv
src/qat2_checker.sv
bench/tb_q15_atan2_polynomial_top.sv
